>>> src/mf2d_pkg.sv
// Package with the shared types and constants of the 2D median filter.
`timescale 1ns / 1ps

package mf2d_pkg;

  localparam int PIXEL_W    = 8;
  localparam int SIZE_CFG_W = 9;
  localparam int RAD_CFG_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               filler;
  } mf2d_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] median;
    logic               last_of_run;
    logic               frame_done;
  } mf2d_out_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
  } mf2d_sort_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSTART,
    ST_LOAD,
    ST_DRAIN,
    ST_SETUP,
    ST_POP,
    ST_EMIT
  } mf2d_state_t;

endpackage

>>> src/mf2d_line_store.sv
// Line store memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mf2d_line_store #(
  parameter int DEPTH = 1792,
  parameter int AW    = 11
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [mf2d_pkg::PIXEL_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [mf2d_pkg::PIXEL_W-1:0] rd_data
);
  import mf2d_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/mf2d_sorter.sv
// Row of insertion cells that keeps the window pixels sorted, with a pop toward cell 0.
`timescale 1ns / 1ps

module mf2d_sorter #(
  parameter int NBUF = 49,
  parameter int CNTW = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mf2d_pkg::mf2d_sort_ctl_t     ctl,
  input  logic [mf2d_pkg::PIXEL_W-1:0] din,
  output logic [mf2d_pkg::PIXEL_W-1:0] head0,
  output logic [mf2d_pkg::PIXEL_W-1:0] head1,
  output logic [CNTW-1:0]              count
);
  import mf2d_pkg::*;

  logic [PIXEL_W-1:0] buf_q    [NBUF];
  logic [PIXEL_W-1:0] buf_next [NBUF];
  logic [NBUF-1:0]    gt;

  // Unused cells act as larger than any pixel, so the new value lands
  // right after the last entry not greater than it.
  for (genvar j = 0; j < NBUF; j++) begin : g_cell
    assign gt[j] = (CNTW'(j) >= count) || (buf_q[j] > din);
    if (j == 0) begin : g_first
      always_comb begin
        buf_next[j] = buf_q[j];
        if (ctl.ins && gt[j]) begin
          buf_next[j] = din;
        end else if (ctl.pop) begin
          buf_next[j] = (NBUF > 1) ? buf_q[(NBUF > 1) ? 1 : 0] : buf_q[j];
        end
      end
    end else begin : g_rest
      always_comb begin
        buf_next[j] = buf_q[j];
        if (ctl.ins && gt[j]) begin
          buf_next[j] = gt[j-1] ? buf_q[j-1] : din;
        end else if (ctl.pop && (j < NBUF - 1)) begin
          buf_next[j] = buf_q[(j < NBUF - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NBUF; k++) begin
      buf_q[k] <= buf_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      count <= '0;
    end else if (ctl.ins) begin
      count <= count + CNTW'(1);
    end else if (ctl.pop) begin
      count <= count - CNTW'(1);
    end
  end

  assign head0 = buf_q[0];
  assign head1 = buf_q[(NBUF > 1) ? 1 : 0];

endmodule

>>> src/median_filter_2d_clipped_window_core.sv
// Top level of the streaming 2D median filter with a clipped square window.
`timescale 1ns / 1ps

// Usage: pixels of a square image enter on the in channel (valid/ready) in
// raster order, one transaction per pixel. After the frame the host sends
// radius*image_size filler transactions so that the last rows come out.
// Results leave on the out channel (valid/ready); an input transaction causes
// zero to radius+1 results, and the last of them carries last_of_run. The
// bottom right pixel of the frame carries frame_done. Outputs lag the input
// by radius rows and radius columns; a row-end input flushes the rest of the
// output row as one run.
// The cfg channel writes image_size (index 0) and radius (index 1); any such
// write restarts the frame. Writes are taken only while the block is idle,
// and an input transaction waits while a write is offered.
// Throughput: one input at a time. Each result reads its window, n pixels
// with n up to (2*MAX_RADIUS+1)^2, through the single read port of the line
// store, one per cycle, into the insertion sorter, then pops (n-1)/2 entries.
// in_ready is low while results are being computed.
// Reset clears positions and the sequencer and sets the registers to
// image_size 256 and radius 1; the line store is not cleared, since every
// read touches only entries written earlier in the same frame. When the
// receiver stalls, the finished result holds in the output register and the
// sequencer waits before loading the next one.
module median_filter_2d_clipped_window_core #(
  parameter int MAX_SIZE   = 256,
  parameter int MAX_RADIUS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mf2d_pkg::mf2d_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mf2d_pkg::mf2d_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mf2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf2d_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mf2d_pkg::*;

  localparam int WIN_ROWS = 2 * MAX_RADIUS + 1;
  localparam int NBUF     = WIN_ROWS * WIN_ROWS;
  localparam int CNTW     = $clog2(NBUF + 1);
  localparam int DEPTH    = WIN_ROWS * MAX_SIZE;
  localparam int AW       = $clog2(DEPTH);
  localparam int SW       = $clog2(MAX_SIZE + 1);
  localparam int RADW     = $clog2(MAX_RADIUS + 1);
  localparam int RW       = $clog2(MAX_SIZE + MAX_RADIUS);
  localparam int XW       = RW + 1;
  localparam int SLW      = (WIN_ROWS > 1) ? $clog2(WIN_ROWS) : 1;
  localparam int DW       = $clog2(2 * MAX_RADIUS + 1);

  // Configuration registers and their clamped values.
  logic [SIZE_CFG_W-1:0] image_size;
  logic [RAD_CFG_W-1:0]  radius;
  logic [SW-1:0]         s_eff;
  logic [RADW-1:0]       r_eff;
  logic [XW-1:0]         sx;
  logic [XW-1:0]         rx;
  logic [XW-1:0]         s_m1;

  always_comb begin
    if (image_size == '0) begin
      s_eff = SW'(1);
    end else if (32'(image_size) > 32'(MAX_SIZE)) begin
      s_eff = SW'(MAX_SIZE);
    end else begin
      s_eff = SW'(image_size);
    end
    if (32'(radius) > 32'(MAX_RADIUS)) begin
      r_eff = RADW'(MAX_RADIUS);
    end else begin
      r_eff = RADW'(radius);
    end
  end

  assign sx   = XW'(s_eff);
  assign rx   = XW'(r_eff);
  assign s_m1 = sx - XW'(1);

  // Stream position and the line-store slot of the current row.
  logic [RW-1:0]  row_pos;
  logic [RW-1:0]  col_pos;
  logic [SLW-1:0] wslot;

  // Current item and current output window.
  logic [RW-1:0]  item_row;
  logic [SLW-1:0] item_slot;
  logic [RW-1:0]  orow;
  logic [RW-1:0]  oc;
  logic [RW-1:0]  oc_hi;
  logic [RW-1:0]  ra;
  logic [RW-1:0]  ra_end;
  logic [RW-1:0]  cb;
  logic [RW-1:0]  cb_start;
  logic [RW-1:0]  cb_end;
  logic [SLW-1:0] rs;
  logic           rd_pend;
  logic [CNTW-1:0] pops;
  logic           odd;

  mf2d_state_t    state, state_next;
  mf2d_sort_ctl_t sort_ctl;

  logic [PIXEL_W-1:0] rd_data;
  logic [PIXEL_W-1:0] head0, head1;
  logic [CNTW-1:0]    count;

  logic in_acc, cfg_acc, cfg_hit, emit_go;

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && ((cfg_index == CFG_IMAGE_SIZE) || (cfg_index == CFG_RADIUS));
  assign emit_go   = (state == ST_EMIT) && (!out_valid || out_ready);

  // Item decode: wrap a stale position, then find which outputs it releases.
  logic [XW-1:0]  row_e, col_e;
  logic [SLW-1:0] slot_e;
  logic           wrap, is_last, has_out;
  logic [XW-1:0]  lo_e, hi_e;

  always_comb begin
    wrap    = (XW'(row_pos) >= sx + rx) || (XW'(col_pos) >= sx);
    row_e   = wrap ? '0 : XW'(row_pos);
    col_e   = wrap ? '0 : XW'(col_pos);
    slot_e  = wrap ? '0 : wslot;
    is_last = (col_e == s_m1);
    has_out = (row_e >= rx) && (is_last || (col_e >= rx));
    lo_e    = (col_e >= rx) ? col_e - rx : '0;
    hi_e    = is_last ? col_e : col_e - rx;
  end

  // Window bounds of the output at (orow, oc), clipped to the image.
  logic [XW-1:0]  r0, r1, c0, c1, orx, ocx;
  logic [DW-1:0]  d0;
  logic [SLW-1:0] slot0;

  always_comb begin
    orx   = XW'(orow);
    ocx   = XW'(oc);
    r0    = (orx >= rx) ? orx - rx : '0;
    r1    = (orx + rx > s_m1) ? s_m1 : orx + rx;
    c0    = (ocx >= rx) ? ocx - rx : '0;
    c1    = (ocx + rx > s_m1) ? s_m1 : ocx + rx;
    d0    = DW'(XW'(item_row) - r0);
    if (32'(item_slot) >= 32'(d0)) begin
      slot0 = SLW'(32'(item_slot) - 32'(d0));
    end else begin
      slot0 = SLW'(32'(item_slot) + WIN_ROWS - 32'(d0));
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sort_ctl.clr = 1'b0;
    sort_ctl.ins = rd_pend;
    sort_ctl.pop = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && !cfg_acc && has_out) begin
          state_next = ST_WSTART;
        end
      end
      ST_WSTART: begin
        sort_ctl.clr = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if ((cb == cb_end) && (ra == ra_end)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        if (pops == '0) begin
          state_next = ST_EMIT;
        end else begin
          sort_ctl.pop = 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = (oc == oc_hi) ? ST_IDLE : ST_WSTART;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers and stream position.
  logic [XW-1:0] col_inc, row_inc;

  assign col_inc = col_e + XW'(1);
  assign row_inc = row_e + XW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_CFG_W'(256);
      radius     <= RAD_CFG_W'(1);
      row_pos    <= '0;
      col_pos    <= '0;
      wslot      <= '0;
    end else if (cfg_acc) begin
      if (cfg_index == CFG_IMAGE_SIZE) begin
        image_size <= cfg_data[SIZE_CFG_W-1:0];
      end else if (cfg_index == CFG_RADIUS) begin
        radius <= cfg_data[RAD_CFG_W-1:0];
      end
      if (cfg_hit) begin
        row_pos <= '0;
        col_pos <= '0;
        wslot   <= '0;
      end
    end else if (in_acc) begin
      if (col_inc >= sx) begin
        col_pos <= '0;
        if (row_inc >= sx + rx) begin
          row_pos <= '0;
          wslot   <= '0;
        end else begin
          row_pos <= RW'(row_inc);
          wslot   <= (32'(slot_e) == WIN_ROWS - 1) ? '0 : slot_e + SLW'(1);
        end
      end else begin
        col_pos <= RW'(col_inc);
        row_pos <= RW'(row_e);
        wslot   <= slot_e;
      end
    end
  end

  // Item and window registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      item_row  <= RW'(row_e);
      item_slot <= slot_e;
      orow      <= RW'(row_e - rx);
      oc        <= RW'(lo_e);
      oc_hi     <= RW'(hi_e);
    end
    if (state == ST_WSTART) begin
      ra       <= RW'(r0);
      ra_end   <= RW'(r1);
      cb       <= RW'(c0);
      cb_start <= RW'(c0);
      cb_end   <= RW'(c1);
      rs       <= slot0;
    end
    if (state == ST_LOAD) begin
      if (cb == cb_end) begin
        cb <= cb_start;
        ra <= ra + RW'(1);
        rs <= (32'(rs) == WIN_ROWS - 1) ? '0 : rs + SLW'(1);
      end else begin
        cb <= cb + RW'(1);
      end
    end
    if (state == ST_SETUP) begin
      pops <= (count - CNTW'(1)) >> 1;
      odd  <= count[0];
    end else if (state == ST_POP && pops != '0) begin
      pops <= pops - CNTW'(1);
    end
    if (emit_go && (oc != oc_hi)) begin
      oc <= oc + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_LOAD);
    end
  end

  // Line store: write the pixel of an in-frame item, read the window.
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_en   = (state == ST_IDLE) && in_acc && !cfg_acc && (row_e < sx);
  assign wr_addr = AW'(slot_e) * AW'(MAX_SIZE) + AW'(col_e);
  assign rd_addr = AW'(rs) * AW'(MAX_SIZE) + AW'(cb);

  mf2d_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.filler ? '0 : in_data.pixel),
    .rd_en   (state == ST_LOAD),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mf2d_sorter #(
    .NBUF (NBUF),
    .CNTW (CNTW)
  ) u_sort (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sort_ctl),
    .din   (rd_data),
    .head0 (head0),
    .head1 (head1),
    .count (count)
  );

  // Output register.
  logic [PIXEL_W:0] pair_sum;

  assign pair_sum = {1'b0, head0} + {1'b0, head1};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data.median      <= odd ? head0 : pair_sum[PIXEL_W:1];
      out_data.last_of_run <= (oc == oc_hi);
      out_data.frame_done  <= (XW'(orow) == s_m1) && (XW'(oc) == s_m1);
    end
  end

endmodule

>>> src/mf2d_checker.sv
// Port checker for the median filter core and its bind to the top level.
`timescale 1ns / 1ps

module mf2d_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mf2d_pkg::mf2d_out_t out_data
);
  import mf2d_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // The frame's last pixel always closes its run.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.last_of_run)
    else $error("frame_done without last_of_run");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind median_filter_2d_clipped_window_core mf2d_checker u_mf2d_checker (.*);

>>> sim/median_filter_2d_clipped_window_core_test.sv
// Self-checking testbench for the streaming clipped-window 2D median filter.
`timescale 1ns / 1ps

module median_filter_2d_clipped_window_core_test;
  import mf2d_pkg::*;

  localparam int MAX_SIZE   = 256;
  localparam int MAX_RADIUS = 3;
  localparam int WIN_ROWS   = 2 * MAX_RADIUS + 1;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 75;

  // Register indexes outside the register list; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  mf2d_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mf2d_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  median_filter_2d_clipped_window_core #(
    .MAX_SIZE  (MAX_SIZE),
    .MAX_RADIUS(MAX_RADIUS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Pixels waiting to be offered, and medians waiting to come out.
  mf2d_in_t  pixel_queue[$];
  mf2d_out_t median_queue[$];
  int        errors = 0;

  // Shadow of the block: recent rows, scan position and register values.
  logic [7:0]  row_buf[WIN_ROWS][MAX_SIZE];
  int unsigned scan_row = 0;
  int unsigned scan_col = 0;
  int unsigned size_reg = 256;
  int unsigned rad_reg  = 1;

  // Receiver behavior, set per phase by the sequence below.
  bit stall_on   = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done  = 1'b0;
  int hold_left  = 0;

  int burst_left = 0;
  int gap_left   = 0;
  int idle_count = 0;

  function automatic int unsigned clipped_size();
    if (size_reg < 1) return 1;
    if (size_reg > MAX_SIZE) return MAX_SIZE;
    return size_reg;
  endfunction

  function automatic int unsigned clipped_radius();
    return (rad_reg > MAX_RADIUS) ? MAX_RADIUS : rad_reg;
  endfunction

  // Median of the window around (orow, ocol), clipped to the image.
  function automatic logic [7:0] window_median(int orow, int ocol, int s, int r);
    int vals[WIN_ROWS*WIN_ROWS];
    int n;
    int j;
    int v;
    int r0;
    int r1;
    int c0;
    int c1;
    n  = 0;
    r0 = (orow >= r) ? orow - r : 0;
    r1 = (orow + r > s - 1) ? s - 1 : orow + r;
    c0 = (ocol >= r) ? ocol - r : 0;
    c1 = (ocol + r > s - 1) ? s - 1 : ocol + r;
    for (int a = r0; a <= r1; a++) begin
      for (int b = c0; b <= c1; b++) begin
        v = row_buf[a % WIN_ROWS][b];
        j = n;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
        n++;
      end
    end
    if (n % 2 == 1) return vals[n/2];
    return (vals[n/2-1] + vals[n/2]) >> 1;
  endfunction

  // Advances the shadow by one accepted pixel and queues the medians it releases.
  function automatic void predict_medians(mf2d_in_t item);
    int unsigned s;
    int unsigned r;
    int unsigned row;
    int unsigned col;
    int          lo;
    int          hi;
    mf2d_out_t   res;
    s   = clipped_size();
    r   = clipped_radius();
    row = scan_row;
    col = scan_col;
    if (row >= s + r || col >= s) begin
      row = 0;
      col = 0;
    end
    if (row < s) row_buf[row % WIN_ROWS][col] = item.filler ? 8'd0 : item.pixel;
    if (row >= r) begin
      lo = 1;
      hi = 0;
      if (col == s - 1) begin
        lo = (col >= r) ? col - r : 0;
        hi = col;
      end else if (col >= r) begin
        lo = col - r;
        hi = col - r;
      end
      for (int oc = lo; oc <= hi; oc++) begin
        res.median      = window_median(row - r, oc, s, r);
        res.last_of_run = (oc == hi);
        res.frame_done  = (row - r == s - 1) && (oc == s - 1);
        median_queue.push_back(res);
      end
    end
    col++;
    if (col >= s) begin
      col = 0;
      row++;
      if (row >= s + r) row = 0;
    end
    scan_row = row;
    scan_col = col;
  endfunction

  // Sender: bursts of transactions separated by random gaps. Prediction happens
  // at the edge where a pixel is accepted, so the expectation is always queued
  // before any result it causes can leave the block.
  always @(posedge clk) begin : pixel_driver
    logic     next_valid;
    mf2d_in_t next_data;
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) predict_medians(in_data);
      next_valid = in_valid && !in_ready;
      next_data  = in_data;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_queue.size() > 0) begin
          next_data  = pixel_queue.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // Receiver: checks each result transaction against the oldest expectation.
  // A one-time long hold lets the block fill up and push back on its input.
  always @(posedge clk) begin : median_monitor
    mf2d_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (median_queue.size() == 0) begin
          $error("unexpected result: median %0d", out_data.median);
          errors++;
        end else begin
          want = median_queue.pop_front();
          if (out_data.median !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, out_data.median);
            errors++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_data.last_of_run);
            errors++;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done,
                   out_data.frame_done);
            errors++;
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("FAIL median_filter_2d_clipped_window_core");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Waits until all pixels are taken and every median has come out, then
  // leaves room for a pixel still being processed that releases no result.
  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid || median_queue.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Register write; the shadow is updated at the accepting edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IMAGE_SIZE || idx == CFG_RADIUS) begin
      if (idx == CFG_IMAGE_SIZE) size_reg = value[CFG_DATA_W-1:0];
      else rad_reg = value[RAD_CFG_W-1:0];
      scan_row = 0;
      scan_col = 0;
    end
  endtask

  task automatic add_pixel(int unsigned value, bit is_filler);
    mf2d_in_t item;
    item.pixel  = value[7:0];
    item.filler = is_filler;
    pixel_queue.push_back(item);
  endtask

  function automatic int unsigned random_pixel();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Queues count transactions of a frame of side s with radius r. Inside the
  // image an occasional filler shows up; past it most transactions are fillers
  // but some carry a pixel that must be discarded.
  task automatic queue_frame(int s, int r, int count);
    for (int i = 0; i < count; i++) begin
      if (i / s < s) add_pixel(random_pixel(), $urandom_range(0, 15) == 0);
      else add_pixel(random_pixel(), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin : sequencer
    int s;
    int r;
    int full;
    int count;
    int rand_total;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Size zero behaves as a one-pixel image, with the reset radius of one.
    write_reg(CFG_IMAGE_SIZE, 0);
    add_pixel(255, 1'b0);
    add_pixel(0, 1'b1);
    wait_drained();

    // Radius zero on a one-pixel image: the result comes straight back.
    write_reg(CFG_RADIUS, 0);
    add_pixel(0, 1'b0);
    wait_drained();

    // Radius larger than the image: each output row comes out as one run at a row end.
    write_reg(CFG_IMAGE_SIZE, 2);
    write_reg(CFG_RADIUS, 3);
    add_pixel(255, 1'b0);
    add_pixel(0, 1'b0);
    add_pixel(170, 1'b0);
    add_pixel(85, 1'b0);
    for (int i = 0; i < 6; i++) add_pixel(i * 51, 1'b1);
    wait_drained();

    // A filler inside the image is stored as zero. A write to an unused index
    // halfway through must not restart the frame.
    write_reg(CFG_IMAGE_SIZE, 3);
    write_reg(CFG_RADIUS, 1);
    add_pixel(200, 1'b0);
    add_pixel(37, 1'b1);
    add_pixel(255, 1'b0);
    add_pixel(90, 1'b0);
    wait_drained();
    write_reg(CFG_SPARE_A, 511);
    write_reg(CFG_SPARE_B, 0);
    add_pixel(1, 1'b0);
    add_pixel(254, 1'b0);
    add_pixel(128, 1'b0);
    add_pixel(127, 1'b0);
    add_pixel(64, 1'b0);
    add_pixel(33, 1'b0);
    add_pixel(99, 1'b1);
    add_pixel(12, 1'b1);
    wait_drained();

    // Size above the maximum is clipped; radius zero gives one result each.
    write_reg(CFG_IMAGE_SIZE, 511);
    write_reg(CFG_RADIUS, 0);
    add_pixel(0, 1'b0);
    add_pixel(255, 1'b0);
    add_pixel(77, 1'b1);
    add_pixel(170, 1'b0);
    wait_drained();

    // The largest legal size with the widest window, cut short.
    write_reg(CFG_IMAGE_SIZE, 256);
    write_reg(CFG_RADIUS, 3);
    add_pixel(9, 1'b0);
    add_pixel(250, 1'b0);
    wait_drained();

    // Random frames: mostly complete, some cut short by the next write.
    rand_total = 0;
    while (rand_total < RAND_ITEMS) begin
      if (rand_total == 0) begin
        s = 6;
        r = 1;
      end else begin
        s = $urandom_range(1, 6);
        r = $urandom_range(0, 3);
      end
      full  = s * s + r * s;
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full) : full;
      stall_on = $urandom_range(0, 1);
      write_reg(CFG_IMAGE_SIZE, s);
      write_reg(CFG_RADIUS, r);
      if (rand_total == 0) begin
        // Keep the receiver off for a long stretch while pixels keep coming.
        stall_on   = 1'b0;
        hold_armed = 1'b1;
        count      = full;
      end
      queue_frame(s, r, count);
      rand_total += count;
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && median_queue.size() == 0) begin
      $display("PASS median_filter_2d_clipped_window_core");
    end else begin
      $display("FAIL median_filter_2d_clipped_window_core");
    end
    $finish;
  end

endmodule
